// ===== hdl/ppt_pkg.sv =====
// ppt_pkg: shared constants and types for the push/pop trace classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppt_pkg;
  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 16;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef enum logic [2:0] {
    VERDICT_IMPOSSIBLE = 3'd0,
    VERDICT_QUEUE      = 3'd1,
    VERDICT_STACK      = 3'd2,
    VERDICT_PRIO       = 3'd3,
    VERDICT_NOT_SURE   = 3'd4,
    VERDICT_OVERFLOW   = 3'd5
  } verdict_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Request from the top level to the heap engine.
  typedef struct packed {
    logic   start;
    logic   pop;
    value_t value;
  } heap_req_t;

  // Status from the heap engine back to the top level.
  typedef struct packed {
    logic done;
    logic alive;
    logic overflow;
  } heap_sts_t;
endpackage
`default_nettype wire

// ===== hdl/ppt_heap.sv =====
// ppt_heap: max-first binary heap in one synchronous RAM; push sifts up a level
// per S_UP_RD/S_UP_CHK pass, pop sinks one per S_DN_RDA/RDB/CHK pass. Depends on ppt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppt_heap (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ppt_pkg::heap_req_t   req,
  input  wire                  clear,
  output ppt_pkg::heap_sts_t   sts
);
  import ppt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CHK, S_DN_RDA, S_DN_RDB, S_DN_CHK, S_POP_RD, S_POP_CHK
  } state_t;

  value_t mem [DEPTH];
  addr_t  rd_addr;
  value_t rd_data_r;
  logic   wr_en;
  addr_t  wr_addr;
  value_t wr_data;

  state_t state_r;
  cnt_t   count_r;
  logic   alive_r, ovf_r, done_r;
  addr_t  idx_r, chl_r;
  value_t key_r, left_r;
  logic   has_r_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // Child indices; computed wide so that 2i+1 beyond the count is visible.
  logic [CNT_BITS:0] lc_w, rc_w;
  assign lc_w = {idx_r, 1'b1} + (CNT_BITS+1)'(0);
  assign rc_w = lc_w + (CNT_BITS+1)'(1);
  addr_t par_w;
  assign par_w = addr_t'((idx_r - addr_t'(1)) >> 1);

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = key_r;
    unique case (state_r)
      S_UP_RD: begin
        rd_addr = par_w;
        // sift-up reached the root: the key lands there
        wr_en   = (idx_r == '0);
      end
      S_UP_CHK: begin
        if (rd_data_r < key_r) begin
          wr_en = 1'b1; wr_data = rd_data_r;
        end else begin
          wr_en = 1'b1;
        end
      end
      S_POP_RD: rd_addr = '0;
      S_POP_CHK: rd_addr = addr_t'(count_r - cnt_t'(1));
      S_DN_RDA: rd_addr = addr_t'(lc_w);
      S_DN_RDB: rd_addr = addr_t'(rc_w);
      S_DN_CHK: begin
        wr_en = 1'b1;
        if (has_r_r && rd_data_r > left_r) begin
          if (rd_data_r > key_r) wr_data = rd_data_r;
        end else if (left_r > key_r) begin
          wr_data = left_r;
        end
      end
      default: ;
    endcase
    if (state_r == S_IDLE && req.start && !req.pop && alive_r
        && count_r != cnt_t'(DEPTH) && count_r == '0) begin
      wr_en = 1'b1; wr_addr = '0; wr_data = req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      state_r <= S_IDLE;
      count_r <= '0;
      alive_r <= 1'b1;
      ovf_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (req.start) begin
          key_r <= req.value;
          if (!alive_r) begin
            done_r <= 1'b1;
          end else if (!req.pop) begin
            if (count_r == cnt_t'(DEPTH)) begin
              ovf_r <= 1'b1; done_r <= 1'b1;
            end else begin
              idx_r   <= addr_t'(count_r);
              count_r <= count_r + cnt_t'(1);
              if (count_r == '0) done_r <= 1'b1;
              else state_r <= S_UP_RD;
            end
          end else if (count_r == '0) begin
            alive_r <= 1'b0; done_r <= 1'b1;
          end else begin
            state_r <= S_POP_RD;
          end
        end
        S_UP_RD: begin
          if (idx_r == '0) begin
            state_r <= S_IDLE; done_r <= 1'b1;
          end else state_r <= S_UP_CHK;
        end
        S_UP_CHK: begin
          if (rd_data_r < key_r) begin
            idx_r   <= par_w;
            state_r <= S_UP_RD;
          end else begin
            state_r <= S_IDLE; done_r <= 1'b1;
          end
        end
        S_POP_RD: state_r <= S_POP_CHK;
        S_POP_CHK: begin
          if (rd_data_r != key_r) begin
            alive_r <= 1'b0; state_r <= S_IDLE; done_r <= 1'b1;
          end else begin
            count_r <= count_r - cnt_t'(1);
            idx_r   <= '0;
            state_r <= S_DN_RDA;
          end
        end
        S_DN_RDA: begin
          // first pass through: load the last element as the key
          if (idx_r == '0) key_r <= rd_data_r;
          if ({1'b0, lc_w} >= {2'b0, count_r}) begin
            state_r <= S_DN_CHK; has_r_r <= 1'b0; left_r <= '0;
          end else state_r <= S_DN_RDB;
        end
        S_DN_RDB: begin
          left_r  <= rd_data_r;
          has_r_r <= ({1'b0, rc_w} < {2'b0, count_r});
          state_r <= S_DN_CHK;
        end
        S_DN_CHK: begin
          has_r_r <= 1'b0;
          if ({1'b0, lc_w} >= {2'b0, count_r}) begin
            state_r <= S_IDLE; done_r <= 1'b1;
          end else if (has_r_r && rd_data_r > left_r) begin
            if (rd_data_r > key_r) begin idx_r <= addr_t'(rc_w); state_r <= S_DN_RDA; end
            else begin state_r <= S_IDLE; done_r <= 1'b1; end
          end else if (left_r > key_r) begin
            idx_r <= addr_t'(lc_w); state_r <= S_DN_RDA;
          end else begin
            state_r <= S_IDLE; done_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign sts = '{done: done_r, alive: alive_r, overflow: ovf_r};

  a_heap_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH)) else $error("heap count beyond depth");
  a_heap_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == S_IDLE)) else $error("heap done while walking");
  a_heap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (state_r == S_IDLE)) else $error("heap started while busy");
endmodule
`default_nettype wire

// ===== hdl/push_pop_trace_classifier_top.sv =====
// Top level of the push/pop trace classifier; holds the queue and stack
// RAMs and the verdict logic, and instantiates ppt_heap. Depends on ppt_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One word at a time is replayed against a FIFO, a LIFO and a max-first heap.
// Input is held off while a word is in flight and while a verdict waits in the
// output register. Queue and stack each check a registered read of their own RAM.
// Each word goes through S_READ and then S_WAIT, which waits for the heap step
// to finish; a heap push climbs a level per pass of S_UP_RD and S_UP_CHK, a
// heap pop checks the root and sinks a level per pass of S_DN_RDA, S_DN_RDB
// and S_DN_CHK. The verdict word on last_of_trace is held in an output
// register, and all state clears once it is produced.
module push_pop_trace_classifier_top (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire                    in_opcode,
  input  wire [15:0]             in_value,
  input  wire                    in_last_of_trace,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [2:0]             out_verdict
);
  import ppt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WAIT} state_t;
  state_t state_r;

  value_t fifo_mem [DEPTH];
  value_t stack_mem [DEPTH];
  value_t fifo_rd_r, stack_rd_r;
  addr_t  fifo_head_r;
  cnt_t   fifo_cnt_r, stack_cnt_r;
  logic   fifo_alive_r, stack_alive_r, ovf_r;
  logic   pop_r, last_r, clear_r;
  logic   hdone_r;
  value_t val_r;

  heap_req_t hreq;
  heap_sts_t hsts;

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid;

  // Queue and stack RAMs: write on push, read head / top on accept.
  addr_t tail_w;
  assign tail_w = fifo_head_r + addr_t'(fifo_cnt_r);
  always_ff @(posedge clk) begin
    if (accept && !in_opcode && fifo_alive_r && fifo_cnt_r != cnt_t'(DEPTH))
      fifo_mem[tail_w] <= in_value;
    if (accept && !in_opcode && stack_alive_r && stack_cnt_r != cnt_t'(DEPTH))
      stack_mem[addr_t'(stack_cnt_r)] <= in_value;
    fifo_rd_r  <= fifo_mem[fifo_head_r];
    stack_rd_r <= stack_mem[addr_t'(stack_cnt_r - cnt_t'(1))];
  end

  assign hreq = '{start: accept, pop: in_opcode, value: in_value};

  ppt_heap u_heap (.clk(clk), .rst_n(rst_n), .req(hreq), .clear(clear_r), .sts(hsts));

  verdict_t verdict_w;
  always_comb begin
    priority if (ovf_r || hsts.overflow) verdict_w = VERDICT_OVERFLOW;
    else if (fifo_alive_r) verdict_w = (stack_alive_r || hsts.alive) ? VERDICT_NOT_SURE
                                                                      : VERDICT_QUEUE;
    else if (stack_alive_r) verdict_w = hsts.alive ? VERDICT_NOT_SURE : VERDICT_STACK;
    else if (hsts.alive) verdict_w = VERDICT_PRIO;
    else verdict_w = VERDICT_IMPOSSIBLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fifo_head_r <= '0; fifo_cnt_r <= '0; stack_cnt_r <= '0;
      fifo_alive_r <= 1'b1; stack_alive_r <= 1'b1; ovf_r <= 1'b0;
      out_valid <= 1'b0; clear_r <= 1'b0; hdone_r <= 1'b0;
    end else begin
      clear_r <= 1'b0;
      // heap may finish while we are still in S_READ; hdone_r registers that pulse for S_WAIT
      hdone_r <= hsts.done;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (accept) begin
          pop_r <= in_opcode; val_r <= in_value; last_r <= in_last_of_trace;
          if (!in_opcode) begin
            if (fifo_alive_r) begin
              if (fifo_cnt_r == cnt_t'(DEPTH)) ovf_r <= 1'b1;
              else fifo_cnt_r <= fifo_cnt_r + cnt_t'(1);
            end
            if (stack_alive_r) begin
              if (stack_cnt_r == cnt_t'(DEPTH)) ovf_r <= 1'b1;
              else stack_cnt_r <= stack_cnt_r + cnt_t'(1);
            end
          end
          state_r <= S_READ;
        end
        S_READ: begin
          if (pop_r) begin
            if (fifo_alive_r) begin
              if (fifo_cnt_r == '0 || fifo_rd_r != val_r) fifo_alive_r <= 1'b0;
              else begin
                fifo_head_r <= fifo_head_r + addr_t'(1);
                fifo_cnt_r  <= fifo_cnt_r - cnt_t'(1);
              end
            end
            if (stack_alive_r) begin
              if (stack_cnt_r == '0 || stack_rd_r != val_r) stack_alive_r <= 1'b0;
              else stack_cnt_r <= stack_cnt_r - cnt_t'(1);
            end
          end
          state_r <= S_WAIT;
        end
        S_WAIT: if (hsts.done || hdone_r) begin
          state_r <= S_IDLE;
          if (last_r) begin
            out_valid   <= 1'b1;
            out_verdict <= verdict_w;
            clear_r     <= 1'b1;
            fifo_head_r <= '0; fifo_cnt_r <= '0; stack_cnt_r <= '0;
            fifo_alive_r <= 1'b1; stack_alive_r <= 1'b1; ovf_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !accept) else $error("accept while busy");
  a_clear_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> out_valid) else $error("clear without verdict");
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_cnt_r <= cnt_t'(DEPTH)) && (stack_cnt_r <= cnt_t'(DEPTH)))
    else $error("count beyond depth");
endmodule
`default_nettype wire

// ===== tb/ppt_checker.sv =====
// ppt_checker: watches both channels of the push/pop trace classifier, predicts
// each verdict word and compares it. Depends on ppt_pkg.
`timescale 1ns / 1ps
module ppt_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_stall,
  input  wire        in_opcode,
  input  wire [15:0] in_value,
  input  wire        in_last_of_trace,
  input  wire        out_valid,
  input  wire        out_stall,
  input  wire [2:0]  out_verdict,
  output int         fail_count,
  output int         pending,
  output int         verdicts_seen
);
  import ppt_pkg::*;

  value_t   q_mem [DEPTH];
  int       q_head, q_cnt;
  value_t   s_mem [DEPTH];
  int       s_cnt;
  value_t   h_mem [DEPTH];
  int       h_cnt;
  bit       q_ok, s_ok, h_ok, ovf;
  verdict_t verdict_q [$];

  function automatic void clear_model();
    q_head = 0; q_cnt = 0; s_cnt = 0; h_cnt = 0;
    q_ok = 1; s_ok = 1; h_ok = 1; ovf = 0;
  endfunction

  task automatic apply_word(logic op, value_t v, logic last);
    int i, p, c, n;
    value_t tail_v;
    verdict_t vd;
    if (q_ok) begin
      if (op == OP_PUSH) begin
        if (q_cnt >= DEPTH) ovf = 1;
        else begin
          q_mem[(q_head + q_cnt) % DEPTH] = v;
          q_cnt++;
        end
      end else if (q_cnt == 0 || q_mem[q_head] != v) q_ok = 0;
      else begin
        q_head = (q_head + 1) % DEPTH;
        q_cnt--;
      end
    end
    if (s_ok) begin
      if (op == OP_PUSH) begin
        if (s_cnt >= DEPTH) ovf = 1;
        else begin
          s_mem[s_cnt] = v;
          s_cnt++;
        end
      end else if (s_cnt == 0 || s_mem[s_cnt-1] != v) s_ok = 0;
      else s_cnt--;
    end
    if (h_ok) begin
      if (op == OP_PUSH) begin
        if (h_cnt >= DEPTH) ovf = 1;
        else begin
          i = h_cnt;
          h_cnt++;
          while (i > 0) begin
            p = (i - 1) / 2;
            if (h_mem[p] >= v) break;
            h_mem[i] = h_mem[p];
            i = p;
          end
          h_mem[i] = v;
        end
      end else if (h_cnt == 0 || h_mem[0] != v) h_ok = 0;
      else begin
        h_cnt--;
        tail_v = h_mem[h_cnt];
        n = h_cnt;
        i = 0;
        if (n != 0) begin
          forever begin
            c = 2 * i + 1;
            if (c >= n) break;
            if (c + 1 < n && h_mem[c+1] > h_mem[c]) c++;
            if (h_mem[c] <= tail_v) break;
            h_mem[i] = h_mem[c];
            i = c;
          end
          h_mem[i] = tail_v;
        end
      end
    end
    if (last) begin
      if (ovf) vd = VERDICT_OVERFLOW;
      else if (q_ok) vd = (s_ok || h_ok) ? VERDICT_NOT_SURE : VERDICT_QUEUE;
      else if (s_ok) vd = h_ok ? VERDICT_NOT_SURE : VERDICT_STACK;
      else if (h_ok) vd = VERDICT_PRIO;
      else vd = VERDICT_IMPOSSIBLE;
      verdict_q = {verdict_q, vd};
      clear_model();
    end
  endtask

  initial begin
    fail_count = 0;
    verdicts_seen = 0;
    clear_model();
  end

  assign pending = verdict_q.size();

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) apply_word(in_opcode, in_value, in_last_of_trace);
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          $error("unexpected verdict word %0d", out_verdict);
          fail_count++;
        end else begin
          if (out_verdict !== verdict_q[0]) begin
            $error("verdict: expected %0d, got %0d", verdict_q[0], out_verdict);
            fail_count++;
          end
          void'(verdict_q.pop_front());
        end
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for push_pop_trace_classifier_top; prediction and
// comparison live in ppt_checker. Depends on ppt_pkg and ppt_checker.
`timescale 1ns / 1ps
module tb;
  import ppt_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_opcode = 0;
  logic [15:0] in_value = 0;
  logic        in_last_of_trace = 0;
  logic        out_stall = 0;
  wire         in_stall, out_valid;
  wire [2:0]   out_verdict;
  int          fail_count, pending, verdicts_seen;
  int          words_sent = 0;
  int          idle_cycles = 0;
  bit          hold_off = 0;      // long receiver stall requested
  bit          stim_done = 0;

  localparam int WATCHDOG = 20000;
  localparam int N_WORDS  = 450;

  always #1 clk = ~clk;

  push_pop_trace_classifier_top dut (.*);

  ppt_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_value, .in_last_of_trace,
    .out_valid, .out_stall, .out_verdict, .fail_count, .pending, .verdicts_seen
  );

  // Trace built up before sending: ops, values and where it ends.
  logic   tr_op [$];
  value_t tr_val [$];

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one word; waits for acceptance, then optionally idles.
  task automatic send_word(logic op, value_t v, logic last, bit gaps);
    int g;
    in_valid <= 1;
    in_opcode <= op;
    in_value <= v;
    in_last_of_trace <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_trace(bit gaps);
    for (int i = 0; i < tr_op.size(); i++)
      send_word(tr_op[i], tr_val[i], i == tr_op.size() - 1, gaps);
    tr_op.delete();
    tr_val.delete();
  endtask

  task automatic add(logic op, value_t v);
    tr_op  = {tr_op, op};
    tr_val = {tr_val, v};
  endtask

  // Trace following one discipline: 0 queue, 1 stack, 2 heap; now and then a broken pop at the end.
  // Model kept locally so the pops claim the right values.
  task automatic build_trace(int kind, int len, bit narrow);
    value_t live [$];
    value_t v;
    int idx;
    for (int i = 0; i < len; i++) begin
      if (live.size() == 0 || $urandom_range(0, 1)) begin
        v = narrow ? value_t'($urandom_range(0, 3)) : value_t'($urandom);
        live = {live, v};
        add(OP_PUSH, v);
      end else begin
        idx = 0;
        if (kind == 1) idx = live.size() - 1;
        if (kind == 2) foreach (live[j]) if (live[j] > live[idx]) idx = j;
        v = live[idx];
        live.delete(idx);
        add(OP_POP, v);
      end
    end
    // occasional broken pop
    if ($urandom_range(0, 4) == 0) add(OP_POP, value_t'($urandom));
  endtask

  // Deep heap: n pushes, then every value popped largest first.
  task automatic build_deep_heap(int n);
    value_t live [$];
    value_t v;
    int idx;
    for (int i = 0; i < n; i++) begin
      v = value_t'($urandom);
      live = {live, v};
      add(OP_PUSH, v);
    end
    while (live.size() != 0) begin
      idx = 0;
      foreach (live[j]) if (live[j] > live[idx]) idx = j;
      add(OP_POP, live[idx]);
      live.delete(idx);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when asked.
  initial begin
    int g;
    @(posedge rst_n);
    while (!stim_done || pending != 0) begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      g = gap_len();
      out_stall <= (g != 0);
      if (g > 0) repeat (g) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    out_stall <= 0;
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: single-word traces (push alone fits all three).
    add(OP_PUSH, 16'h0000); send_trace(0);
    add(OP_PUSH, 16'hFFFF); send_trace(0);
    // pop on empty: impossible
    add(OP_POP, 16'h0000); send_trace(0);
    // queue only
    add(OP_PUSH, 16'h0001); add(OP_PUSH, 16'hFFFF); add(OP_POP, 16'h0001); send_trace(1);
    // stack and heap: not sure
    add(OP_PUSH, 16'h0001); add(OP_PUSH, 16'hFFFF); add(OP_POP, 16'hFFFF); send_trace(1);
    // stack only
    add(OP_PUSH, 16'h0005); add(OP_PUSH, 16'h0002); add(OP_POP, 16'h0002); send_trace(1);
    // heap only
    add(OP_PUSH, 16'h0002); add(OP_PUSH, 16'h0009); add(OP_PUSH, 16'h0005);
    add(OP_POP, 16'h0009); send_trace(1);
    // equal values, then a pop that fits none
    add(OP_PUSH, 16'h5555); add(OP_PUSH, 16'h5555); add(OP_POP, 16'h5555);
    add(OP_POP, 16'hAAAA); send_trace(1);

    // Deep heap walk: several levels of sift-up and sift-down.
    build_deep_heap(80);
    send_trace(0);

    // Back-pressure: long receiver hold-off while traces keep coming.
    hold_off = 1;
    for (int t = 0; t < 6; t++) begin
      add(OP_PUSH, value_t'($urandom)); send_trace(0);
    end

    // Random: well-formed traces with random content, some noise.
    while (words_sent < N_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          add(logic'($urandom_range(0, 1)), value_t'($urandom_range(0, 3)));
      end else begin
        build_trace($urandom_range(0, 2), $urandom_range(1, 14), $urandom_range(0, 2) == 0);
      end
      send_trace(1);
    end
    in_valid <= 0;
    stim_done = 1;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("tb summary: %0d words sent, %0d verdicts checked, incl. deep heap and hold-off",
             words_sent, verdicts_seen);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
